@@ hw/rtl/ltc_pkg.sv @@
// ltc_pkg: shared constants, payload types, state codes and helper functions
// for the letter trigram counter. No dependencies; every RTL file of the
// block but ltc_ram refers to it by scoped names.
package ltc_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES = 4096;
   localparam int COUNT_BITS    = 32;
   localparam int INDEX_BITS    = $clog2(TABLE_ENTRIES);
   localparam int FILL_BITS     = INDEX_BITS + 1;
   // Hash table has twice the entries of the key store, so an empty slot always exists
   localparam int SLOT_ENTRIES  = 2 * TABLE_ENTRIES;
   localparam int SLOT_BITS     = $clog2(SLOT_ENTRIES);
   localparam int KEY_BITS      = 24;

   // Front-to-back queue
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

   // Characters
   localparam logic [7:0] PAD_CHAR     = 8'h5F;
   localparam logic [7:0] SPACE_CHAR   = 8'h20;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   localparam logic [31:0] THRESHOLD_RESET = 32'd10;
   localparam logic [12:0] OUT13_MAX       = 13'h1FFF;

   // Command codes
   localparam logic [1:0] CMD_TEXT  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FILLED = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  text_byte;
      logic [11:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] trigram_key;
      logic [31:0] entry_count;
      logic        above_threshold;
      logic [12:0] distinct_entries;
      logic [31:0] total_trigrams;
      logic [12:0] qualifying_entries;
   } rsp_type;

   // Work item handed from front to back
   typedef enum logic [1:0] {
      OP_NOP,
      OP_COUNT,
      OP_READ
   } op_kind_type;

   typedef struct packed {
      op_kind_type         kind;
      logic [KEY_BITS-1:0] key;
      logic [11:0]         index;
   } op_type;

   // Hash slot: maps a key to its dense index
   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [INDEX_BITS-1:0] index;
   } slot_type;

   typedef enum logic [2:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_CHECK,
      STATE_DATA,
      STATE_FINISH
   } state_type;

   typedef enum logic [2:0] {
      ACT_NOP,
      ACT_READ,
      ACT_BAD_INDEX,
      ACT_HIT,
      ACT_INSERT,
      ACT_DROP
   } action_type;

   // XOR fold of the key onto the slot address
   function automatic logic [SLOT_BITS-1:0] slot_hash(input logic [KEY_BITS-1:0] key);
      logic [SLOT_BITS-1:0] h;
      h = '0;
      for (int i = 0; i < KEY_BITS; i++) begin
         h[i % SLOT_BITS] = h[i % SLOT_BITS] ^ key[i];
      end
      return h;
   endfunction

   function automatic logic [12:0] sat13(input logic [31:0] v);
      return (v > 32'(OUT13_MAX)) ? OUT13_MAX : v[12:0];
   endfunction

   function automatic logic [31:0] sat32(input logic [COUNT_BITS-1:0] c);
      logic [63:0] wide;
      wide = 64'(c);
      return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
   endfunction

endpackage

@@ hw/rtl/ltc_ram.sv @@
// ltc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ltc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ltc_front.sv @@
// ltc_front: accepts text/read/flush transfers, tracks the word state and
// turns each transfer into one work item. Depends on ltc_pkg.
module ltc_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  ltc_pkg::req_type req_data,
   output logic            req_stall,
   input  logic            queue_full,
   input  logic            clearing,
   output logic            push,
   output ltc_pkg::op_type push_op
);

   logic [7:0] older_ff, older_in;
   logic [7:0] newer_ff, newer_in;
   logic       phase_ff, phase_in;

   // Hold off while the queue is full or the hash table is being cleared
   assign req_stall = queue_full | clearing;
   assign push      = req_valid & ~req_stall;

   // Classify the transfer and advance the word state
   always_comb begin
      older_in      = older_ff;
      newer_in      = newer_ff;
      phase_in      = phase_ff;
      push_op.kind  = ltc_pkg::OP_NOP;
      push_op.key   = {older_ff, newer_ff, ltc_pkg::PAD_CHAR};
      push_op.index = req_data.entry_index;
      case (req_data.command)
         ltc_pkg::CMD_TEXT: begin
            if (req_data.text_byte inside {ltc_pkg::SPACE_CHAR, ltc_pkg::NEWLINE_CHAR}) begin
               // word end: closing trigram
               if (phase_ff) begin
                  push_op.kind = ltc_pkg::OP_COUNT;
               end
               phase_in = 1'b0;
            end else if (!phase_ff) begin
               // first letter only loads the state
               older_in = ltc_pkg::PAD_CHAR;
               newer_in = req_data.text_byte;
               phase_in = 1'b1;
            end else begin
               push_op.kind = ltc_pkg::OP_COUNT;
               push_op.key  = {older_ff, newer_ff, req_data.text_byte};
               older_in     = newer_ff;
               newer_in     = req_data.text_byte;
            end
         end
         ltc_pkg::CMD_FLUSH: begin
            if (phase_ff) begin
               push_op.kind = ltc_pkg::OP_COUNT;
            end
            phase_in = 1'b0;
         end
         ltc_pkg::CMD_READ: begin
            push_op.kind = ltc_pkg::OP_READ;
         end
         default: begin
            push_op.kind = ltc_pkg::OP_NOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
         phase_ff <= 1'b0;
      end else if (push) begin
         older_ff <= older_in;
         newer_ff <= newer_in;
         phase_ff <= phase_in;
      end
   end

endmodule

@@ hw/rtl/ltc_queue.sv @@
// ltc_queue: short FIFO of work items between front and back.
// Depends on ltc_pkg.
module ltc_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  ltc_pkg::op_type push_op,
   input  logic            pop,
   output ltc_pkg::op_type head,
   output logic            full,
   output logic            empty
);

   ltc_pkg::op_type entries_ff [ltc_pkg::QUEUE_DEPTH];
   logic [ltc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ltc_pkg::QUEUE_PTR_BITS:0]   level_ff, level_in;

   assign full  = (level_ff == (ltc_pkg::QUEUE_PTR_BITS + 1)'(ltc_pkg::QUEUE_DEPTH));
   assign empty = (level_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   // Occupancy
   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

@@ hw/rtl/ltc_engine.sv @@
// ltc_engine: back end. Hash probe, count update, entry reads, threshold
// recount and the response register. Depends on ltc_pkg and ltc_ram.
module ltc_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  ltc_pkg::op_type  head,
   output logic             pop,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data,
   output logic             clearing,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ltc_pkg::rsp_type rsp_data
);

   localparam int IB = ltc_pkg::INDEX_BITS;
   localparam int FB = ltc_pkg::FILL_BITS;
   localparam int SB = ltc_pkg::SLOT_BITS;
   localparam int CB = ltc_pkg::COUNT_BITS;
   localparam int KB = ltc_pkg::KEY_BITS;

   ltc_pkg::state_type  state_ff, state_in;
   ltc_pkg::action_type act_ff, act_in;

   logic [SB-1:0] clr_ff, clr_in;
   logic [SB-1:0] cur_ff, cur_in;
   logic [IB-1:0] idx_ff, idx_in;
   logic [KB-1:0] opkey_ff, opkey_in;
   logic [KB-1:0] rdkey_ff, rdkey_in;
   logic [CB-1:0] cnt_ff, cnt_in;

   logic [FB-1:0] filled_ff, filled_in;
   logic [31:0]   total_ff, total_in;
   logic [FB-1:0] qual_ff, qual_in;
   logic [31:0]   thr_ff;

   // Threshold recount sweep
   logic          rc_active_ff, rc_active_in;
   logic [FB-1:0] rc_addr_ff, rc_addr_in;
   logic          rc_pend_ff;
   logic          rc_issue;
   logic          rc_hit;

   logic             rsp_valid_ff, rsp_valid_in;
   ltc_pkg::rsp_type rsp_ff, rsp_in;
   logic             out_free;

   // RAM ports
   logic              slot_we;
   logic [SB-1:0]     slot_waddr, slot_raddr;
   ltc_pkg::slot_type slot_wdata, slot_rd;
   logic [$bits(ltc_pkg::slot_type)-1:0] slot_rdata;
   logic              key_we;
   logic [IB-1:0]     key_waddr, key_raddr;
   logic [KB-1:0]     key_wdata, key_rdata;
   logic              cnt_we;
   logic [IB-1:0]     cnt_waddr, cnt_raddr;
   logic [CB-1:0]     cnt_wdata, cnt_rdata;

   logic          read_ok;
   logic          slot_match;
   logic          table_full;
   logic [SB-1:0] head_hash;

   assign slot_rd    = ltc_pkg::slot_type'(slot_rdata);
   assign head_hash  = ltc_pkg::slot_hash(head.key);
   assign read_ok    = (32'(head.index) < 32'(filled_ff));
   assign slot_match = slot_rd.valid && (slot_rd.key == opkey_ff);
   assign table_full = (filled_ff == FB'(ltc_pkg::TABLE_ENTRIES));
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign clearing   = (state_ff == ltc_pkg::STATE_CLEAR);
   assign pop        = (state_ff == ltc_pkg::STATE_IDLE) & ~queue_empty
                       & ~rc_active_ff & ~csr_wr_en;

   ltc_ram #(.WIDTH($bits(ltc_pkg::slot_type)), .DEPTH(ltc_pkg::SLOT_ENTRIES)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   ltc_ram #(.WIDTH(KB), .DEPTH(ltc_pkg::TABLE_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   ltc_ram #(.WIDTH(CB), .DEPTH(ltc_pkg::TABLE_ENTRIES)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ltc_pkg::STATE_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ltc_pkg::STATE_IDLE;
            end
         end
         ltc_pkg::STATE_IDLE: begin
            if (pop) begin
               case (head.kind)
                  ltc_pkg::OP_COUNT: state_in = ltc_pkg::STATE_CHECK;
                  ltc_pkg::OP_READ:  state_in = read_ok ? ltc_pkg::STATE_DATA
                                                        : ltc_pkg::STATE_FINISH;
                  default:           state_in = ltc_pkg::STATE_FINISH;
               endcase
            end
         end
         ltc_pkg::STATE_CHECK: begin
            if (slot_match) begin
               state_in = ltc_pkg::STATE_DATA;
            end else if (!slot_rd.valid) begin
               state_in = ltc_pkg::STATE_FINISH;
            end
         end
         ltc_pkg::STATE_DATA: begin
            state_in = ltc_pkg::STATE_FINISH;
         end
         ltc_pkg::STATE_FINISH: begin
            if (out_free) begin
               state_in = ltc_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = ltc_pkg::STATE_IDLE;
         end
      endcase
   end

   // Recount sweep: one count read per cycle over the filled entries
   always_comb begin
      rc_issue     = rc_active_ff && (rc_addr_ff < filled_ff);
      rc_hit       = rc_pend_ff && (64'(cnt_rdata) > 64'(thr_ff));
      rc_addr_in   = rc_issue ? rc_addr_ff + 1'b1 : rc_addr_ff;
      rc_active_in = rc_active_ff && (rc_issue || rc_pend_ff);
      if (csr_wr_en) begin
         rc_addr_in   = '0;
         rc_active_in = 1'b1;
      end
   end

   // Datapath, memory ports and response
   always_comb begin
      act_in       = act_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      opkey_in     = opkey_ff;
      rdkey_in     = rdkey_ff;
      cnt_in       = cnt_ff;
      filled_in    = filled_ff;
      total_in     = total_ff;
      qual_in      = qual_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;

      slot_we    = 1'b0;
      slot_waddr = clr_ff;
      slot_wdata = '0;
      slot_raddr = cur_ff + 1'b1;
      key_we     = 1'b0;
      key_waddr  = idx_ff;
      key_wdata  = opkey_ff;
      cnt_we     = 1'b0;
      cnt_waddr  = idx_ff;
      cnt_wdata  = cnt_ff + 1'b1;

      // read addresses for key and count stores
      if (state_ff == ltc_pkg::STATE_IDLE) begin
         key_raddr = IB'(head.index);
      end else begin
         key_raddr = slot_rd.index;
      end
      if (rc_issue) begin
         cnt_raddr = rc_addr_ff[IB-1:0];
      end else begin
         cnt_raddr = key_raddr;
      end

      case (state_ff)
         ltc_pkg::STATE_CLEAR: begin
            slot_we = 1'b1;
            clr_in  = clr_ff + 1'b1;
         end
         ltc_pkg::STATE_IDLE: begin
            slot_raddr = head_hash;
            cur_in     = head_hash;
            opkey_in   = head.key;
            case (head.kind)
               ltc_pkg::OP_READ: act_in = read_ok ? ltc_pkg::ACT_READ
                                                  : ltc_pkg::ACT_BAD_INDEX;
               default:          act_in = ltc_pkg::ACT_NOP;
            endcase
         end
         ltc_pkg::STATE_CHECK: begin
            // probe result for slot cur_ff
            if (slot_match) begin
               act_in = ltc_pkg::ACT_HIT;
               idx_in = slot_rd.index;
            end else if (slot_rd.valid) begin
               cur_in = cur_ff + 1'b1;
            end else begin
               act_in = table_full ? ltc_pkg::ACT_DROP : ltc_pkg::ACT_INSERT;
            end
         end
         ltc_pkg::STATE_DATA: begin
            rdkey_in = key_rdata;
            cnt_in   = cnt_rdata;
         end
         ltc_pkg::STATE_FINISH: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.status          = ltc_pkg::STATUS_OK;
               rsp_in.trigram_key     = '0;
               rsp_in.entry_count     = '0;
               rsp_in.above_threshold = 1'b0;
               case (act_ff)
                  ltc_pkg::ACT_READ: begin
                     rsp_in.trigram_key     = rdkey_ff;
                     rsp_in.entry_count     = ltc_pkg::sat32(cnt_ff);
                     rsp_in.above_threshold = (64'(cnt_ff) > 64'(thr_ff));
                  end
                  ltc_pkg::ACT_BAD_INDEX: begin
                     rsp_in.status = ltc_pkg::STATUS_NOT_FILLED;
                  end
                  ltc_pkg::ACT_HIT: begin
                     // counts stop at all ones, and the total with them
                     if (cnt_ff != '1) begin
                        cnt_we = 1'b1;
                        if (64'(cnt_ff) == 64'(thr_ff)) begin
                           qual_in = qual_ff + 1'b1;
                        end
                        if (total_ff != '1) begin
                           total_in = total_ff + 32'd1;
                        end
                     end
                  end
                  ltc_pkg::ACT_INSERT: begin
                     slot_we          = 1'b1;
                     slot_waddr       = cur_ff;
                     slot_wdata.valid = 1'b1;
                     slot_wdata.key   = opkey_ff;
                     slot_wdata.index = filled_ff[IB-1:0];
                     key_we           = 1'b1;
                     key_waddr        = filled_ff[IB-1:0];
                     cnt_we           = 1'b1;
                     cnt_waddr        = filled_ff[IB-1:0];
                     cnt_wdata        = CB'(1);
                     filled_in        = filled_ff + 1'b1;
                     if (thr_ff == '0) begin
                        qual_in = qual_ff + 1'b1;
                     end
                     if (total_ff != '1) begin
                        total_in = total_ff + 32'd1;
                     end
                  end
                  ltc_pkg::ACT_DROP: begin
                     rsp_in.status = ltc_pkg::STATUS_FULL;
                  end
                  default: begin
                     rsp_in.status = ltc_pkg::STATUS_OK;
                  end
               endcase
               rsp_in.distinct_entries   = ltc_pkg::sat13(32'(filled_in));
               rsp_in.total_trigrams     = total_in;
               rsp_in.qualifying_entries = ltc_pkg::sat13(32'(qual_in));
            end
         end
         default: begin
            act_in = ltc_pkg::ACT_NOP;
         end
      endcase

      // threshold write restarts the qualifying count
      if (csr_wr_en) begin
         qual_in = '0;
      end else if (rc_hit) begin
         qual_in = qual_ff + 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ltc_pkg::STATE_CLEAR;
         clr_ff       <= '0;
         filled_ff    <= '0;
         total_ff     <= '0;
         qual_ff      <= '0;
         thr_ff       <= ltc_pkg::THRESHOLD_RESET;
         rc_active_ff <= 1'b0;
         rc_addr_ff   <= '0;
         rc_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         act_ff       <= ltc_pkg::ACT_NOP;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         filled_ff    <= filled_in;
         total_ff     <= total_in;
         qual_ff      <= qual_in;
         rc_active_ff <= rc_active_in;
         rc_addr_ff   <= rc_addr_in;
         rc_pend_ff   <= rc_issue & ~csr_wr_en;
         rsp_valid_ff <= rsp_valid_in;
         act_ff       <= act_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      idx_ff   <= idx_in;
      opkey_ff <= opkey_in;
      rdkey_ff <= rdkey_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hw/rtl/letter_trigram_counter_unit.sv @@
// Letter trigram counter: one response per request. A trigram found in the table passes
// the engine states IDLE, CHECK (once per hash probe), DATA and FINISH; inserts and
// drops skip DATA. Stored-entry reads pass IDLE, DATA and FINISH; out-of-range reads, flushes
// and bytes that give no trigram go from IDLE to FINISH. The response is then registered.
// Throughput is set by the engine state machine and the single-read hash slot RAM.
// Synchronous reset; afterwards the 8192-slot hash table is cleared slot by slot with
// req_stall high. A threshold write recounts qualifying entries in a sweep over the filled
// entries.
module letter_trigram_counter_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ltc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ltc_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);

   logic            push;
   logic            pop;
   logic            queue_full;
   logic            queue_empty;
   logic            clearing;
   ltc_pkg::op_type push_op;
   ltc_pkg::op_type head;

   // Front: word splitting and classification
   ltc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .clearing   (clearing),
      .push       (push),
      .push_op    (push_op)
   );

   // Work queue
   ltc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head    (head),
      .full    (queue_full),
      .empty   (queue_empty)
   );

   // Back: table lookup, update and responses
   ltc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
